// ===== sv/dgr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgr_pkg
// Shared widths, constants, segment table and control types for the
// decimal glyph rectangle generator.
// ----------------------------------------------------------------------------
package dgr_pkg;

    localparam int unsigned CoordW  = 12;
    localparam int unsigned ValueW  = 14;
    localparam int unsigned PosW    = 16;
    localparam int unsigned SizeW   = 12;
    localparam int unsigned PaintW  = 32;
    localparam int unsigned DigitW  = 4;
    localparam int unsigned SegW    = 3;
    localparam int unsigned EdgeW   = 21;   // edge position, 1/512 world units
    localparam int unsigned ProdW   = 34;   // edge * frame height
    localparam int unsigned SumW    = 35;   // plus centering offset
    localparam int unsigned ScW     = 28;   // scaled offsets and limits
    localparam int unsigned QuoW    = 19;   // sum >> 9, below 100 * 4096
    localparam int unsigned RecProdW = 39;  // QuoW * 20-bit reciprocal

    localparam int unsigned DefDigits = 4;

    localparam logic [CoordW-1:0] FrameWidthReset  = 12'd640;
    localparam logic [CoordW-1:0] FrameHeightReset = 12'd480;

    localparam logic [15:0] ScaleDen = 16'd51200;    // 512 * 100
    localparam logic [15:0] Recip10  = 16'd52429;    // ceil(2^19 / 10)
    localparam logic [19:0] Recip100 = 20'd671089;   // ceil(2^26 / 100)

    // register index, taken from paddr[2]
    localparam logic RegFrameWidth  = 1'b0;
    localparam logic RegFrameHeight = 1'b1;

    // one rectangle: center offset and half extent, in half glyph sizes
    typedef struct packed {
        logic signed [3:0] dx;
        logic signed [3:0] dy;
        logic signed [3:0] hx;
        logic signed [3:0] hy;
    } t_seg;

    typedef struct packed {
        logic            load;
        logic            digit;
        logic            calc;
        logic            mul;
        logic            add;
        logic            emit;
        logic            pen_step;
        logic            last;
        logic [SegW-1:0] seg;
    } t_dp_cmd;

    typedef struct packed {
        logic [SegW-1:0] seg_cnt;
        logic            last_dig;
        logic            out_free;
    } t_dp_status;

    function automatic t_seg mk(input int dx, input int dy, input int hx, input int hy);
        t_seg s;
        s.dx = 4'(dx);
        s.dy = 4'(dy);
        s.hx = 4'(hx);
        s.hy = 4'(hy);
        return s;
    endfunction

    function automatic t_seg seg_entry(input logic [DigitW-1:0] d, input logic [SegW-1:0] k);
        t_seg s;
        case ({d, k})
            {4'd0, 3'd0}: s = mk(-2,  0, 1, 5);
            {4'd0, 3'd1}: s = mk( 2,  0, 1, 5);
            {4'd0, 3'd2}: s = mk( 0, -4, 1, 1);
            {4'd0, 3'd3}: s = mk( 0,  4, 1, 1);
            {4'd1, 3'd0}: s = mk( 2,  0, 1, 5);
            {4'd2, 3'd0}: s = mk( 0,  4, 3, 1);
            {4'd2, 3'd1}: s = mk( 0,  0, 3, 1);
            {4'd2, 3'd2}: s = mk( 0, -4, 3, 1);
            {4'd2, 3'd3}: s = mk( 2,  2, 1, 1);
            {4'd2, 3'd4}: s = mk(-2, -2, 1, 1);
            {4'd3, 3'd0}: s = mk( 0,  4, 3, 1);
            {4'd3, 3'd1}: s = mk( 0,  0, 3, 1);
            {4'd3, 3'd2}: s = mk( 2,  2, 1, 1);
            {4'd3, 3'd3}: s = mk( 2, -2, 1, 3);
            {4'd3, 3'd4}: s = mk( 0, -4, 3, 1);
            {4'd4, 3'd0}: s = mk( 0,  0, 1, 1);
            {4'd4, 3'd1}: s = mk(-2,  2, 1, 3);
            {4'd4, 3'd2}: s = mk( 2,  0, 1, 5);
            {4'd5, 3'd0}: s = mk( 0,  4, 3, 1);
            {4'd5, 3'd1}: s = mk( 0,  0, 3, 1);
            {4'd5, 3'd2}: s = mk( 0, -4, 3, 1);
            {4'd5, 3'd3}: s = mk(-2,  2, 1, 1);
            {4'd5, 3'd4}: s = mk( 2, -2, 1, 1);
            {4'd6, 3'd0}: s = mk( 0,  4, 3, 1);
            {4'd6, 3'd1}: s = mk( 0,  0, 3, 1);
            {4'd6, 3'd2}: s = mk( 0, -4, 3, 1);
            {4'd6, 3'd3}: s = mk( 2,  2, 1, 1);
            {4'd6, 3'd4}: s = mk(-2, -2, 1, 1);
            {4'd6, 3'd5}: s = mk( 2, -2, 1, 1);
            {4'd7, 3'd0}: s = mk( 0,  4, 3, 1);
            {4'd7, 3'd1}: s = mk( 2,  0, 1, 5);
            {4'd8, 3'd0}: s = mk( 0,  4, 3, 1);
            {4'd8, 3'd1}: s = mk( 0,  0, 3, 1);
            {4'd8, 3'd2}: s = mk( 0, -4, 3, 1);
            {4'd8, 3'd3}: s = mk( 2,  2, 1, 1);
            {4'd8, 3'd4}: s = mk(-2, -2, 1, 1);
            {4'd8, 3'd5}: s = mk( 2, -2, 1, 1);
            {4'd8, 3'd6}: s = mk(-2,  2, 1, 1);
            {4'd9, 3'd0}: s = mk( 0,  4, 3, 1);
            {4'd9, 3'd1}: s = mk( 0,  0, 3, 1);
            {4'd9, 3'd2}: s = mk( 2,  2, 1, 1);
            {4'd9, 3'd3}: s = mk( 2, -2, 1, 3);
            {4'd9, 3'd4}: s = mk(-2,  2, 1, 1);
            default:      s = mk( 0,  0, 0, 0);
        endcase
        return s;
    endfunction

    function automatic logic [SegW-1:0] seg_count(input logic [DigitW-1:0] d);
        logic [SegW-1:0] c;
        case (d)
            4'd0:    c = 3'd4;
            4'd1:    c = 3'd1;
            4'd2:    c = 3'd5;
            4'd3:    c = 3'd5;
            4'd4:    c = 3'd3;
            4'd5:    c = 3'd5;
            4'd6:    c = 3'd6;
            4'd7:    c = 3'd2;
            4'd8:    c = 3'd7;
            4'd9:    c = 3'd5;
            default: c = 3'd1;
        endcase
        return c;
    endfunction

    // largest number with the given count of decimal digits
    function automatic int unsigned max_value(input int unsigned digits);
        int unsigned v;
        v = 1;
        for (int unsigned i = 0; i < digits; i++) begin
            v = v * 10;
        end
        return v - 1;
    endfunction

endpackage
`default_nettype wire

// ===== sv/dgr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgr_if
// Valid/ready channels: number items in, rectangle items out.
// ----------------------------------------------------------------------------
interface dgr_in_if;
    logic                     valid;
    logic                     ready;
    logic [13:0]              value;
    logic signed [15:0]       pos_x;
    logic signed [15:0]       pos_y;
    logic [11:0]              glyph_size;
    logic [31:0]              paint;

    modport source (output valid, value, pos_x, pos_y, glyph_size, paint, input ready);
    modport sink   (input valid, value, pos_x, pos_y, glyph_size, paint, output ready);
endinterface

interface dgr_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] right;
    logic [11:0] bottom;
    logic [31:0] fill;
    logic        final_res;

    modport source (output valid, left, top, right, bottom, fill, final_res, input ready);
    modport sink   (input valid, left, top, right, bottom, fill, final_res, output ready);
endinterface
`default_nettype wire

// ===== sv/dgr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgr_ctrl
// Sequencer: one digit step, then four steps per rectangle of the digit.
// ----------------------------------------------------------------------------
module dgr_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire dgr_pkg::t_dp_status i_status,
    output dgr_pkg::t_dp_cmd         o_cmd
);
    import dgr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIGIT,
        S_CALC,
        S_MUL,
        S_ADD,
        S_DIV
    } t_state;

    t_state          r_state, n_state;
    logic [SegW-1:0] r_seg, n_seg;
    logic            w_last_seg;

    assign w_last_seg = (r_seg == (i_status.seg_cnt - 3'd1));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_seg   = r_seg;
        o_cmd   = '0;
        o_cmd.seg = r_seg;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIGIT;
                end
            end
            S_DIGIT: begin
                o_cmd.digit = 1'b1;
                n_seg       = '0;
                n_state     = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = w_last_seg && i_status.last_dig;
                    if (w_last_seg) begin
                        if (i_status.last_dig) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.pen_step = 1'b1;
                            n_state        = S_DIGIT;
                        end
                    end else begin
                        n_seg   = r_seg + 3'd1;
                        n_state = S_CALC;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seg   <= '0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
        end
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("rectangle emitted into a full output slot");

    a_accept_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DIGIT))
        else $error("accepted item did not start a digit step");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_seg < i_status.seg_cnt))
        else $error("segment index beyond the digit's segment count");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.last |=> (r_state == S_IDLE))
        else $error("final rectangle did not end the item");
`endif

endmodule
`default_nettype wire

// ===== sv/dgr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgr_datapath
// Digit split, edge positions, pixel scaling and clamping, output register.
// ----------------------------------------------------------------------------
module dgr_datapath #(
    parameter int unsigned DIGITS = dgr_pkg::DefDigits
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dgr_pkg::t_dp_cmd                  i_cmd,
    output dgr_pkg::t_dp_status                    o_status,
    input  wire logic [dgr_pkg::CoordW-1:0]        i_frame_width,
    input  wire logic [dgr_pkg::CoordW-1:0]        i_frame_height,
    input  wire logic [dgr_pkg::ValueW-1:0]        i_value,
    input  wire logic signed [dgr_pkg::PosW-1:0]   i_pos_x,
    input  wire logic signed [dgr_pkg::PosW-1:0]   i_pos_y,
    input  wire logic [dgr_pkg::SizeW-1:0]         i_glyph_size,
    input  wire logic [dgr_pkg::PaintW-1:0]        i_paint,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [dgr_pkg::CoordW-1:0]             o_left,
    output logic [dgr_pkg::CoordW-1:0]             o_top,
    output logic [dgr_pkg::CoordW-1:0]             o_right,
    output logic [dgr_pkg::CoordW-1:0]             o_bottom,
    output logic [dgr_pkg::PaintW-1:0]             o_fill,
    output logic                                   o_final_res
);
    import dgr_pkg::*;

    localparam int unsigned MaxV = max_value(DIGITS);

    // number and pen
    logic [ValueW-1:0]       r_num;
    logic [DigitW-1:0]       r_digit;
    logic                    r_last;
    logic signed [EdgeW-1:0] r_pen;
    logic signed [EdgeW-1:0] r_cy;
    logic [SizeW-1:0]        r_size;
    logic [PaintW-1:0]       r_paint;
    // per axis: 0 = x, 1 = y
    logic [ScW-1:0]          r_off    [2];
    logic [ScW-1:0]          r_lim_sc [2];
    logic [CoordW-1:0]       r_lim    [2];
    // lanes: left, top, right, bottom
    logic signed [EdgeW-1:0] r_edge [4];
    logic signed [ProdW-1:0] r_prod [4];
    logic [QuoW-1:0]         r_m    [4];
    logic                    r_neg  [4];
    logic                    r_sat  [4];
    logic                    r_out_valid;

    logic [ValueW-1:0]       w_sat_num;
    logic [29:0]             w_qprod;
    logic [10:0]             w_q;
    logic [ValueW-1:0]       w_rem;
    t_seg                    w_seg;
    logic signed [4:0]       w_coef [4];
    logic signed [17:0]      w_term [4];
    logic signed [EdgeW-1:0] w_edge [4];
    logic signed [12:0]      w_hgt;
    logic [SumW-1:0]         w_sum  [4];
    logic [RecProdW-1:0]     w_rprod [4];
    logic [CoordW-1:0]       w_res  [4];
    logic [EdgeW-1:0]        w_pen_dec;

    assign w_sat_num = (32'(i_value) > MaxV) ? ValueW'(MaxV) : i_value;

    // divide by ten: reciprocal multiply, exact below 2^18
    assign w_qprod = 30'(r_num) * 30'(Recip10);
    assign w_q     = w_qprod[29:19];
    assign w_rem   = r_num - ValueW'({w_q, 3'b000}) - ValueW'({w_q, 1'b0});

    assign w_seg     = seg_entry(r_digit, i_cmd.seg);
    assign w_coef[0] = {w_seg.dx[3], w_seg.dx} - {w_seg.hx[3], w_seg.hx};
    assign w_coef[1] = {w_seg.dy[3], w_seg.dy} - {w_seg.hy[3], w_seg.hy};
    assign w_coef[2] = {w_seg.dx[3], w_seg.dx} + {w_seg.hx[3], w_seg.hx};
    assign w_coef[3] = {w_seg.dy[3], w_seg.dy} + {w_seg.hy[3], w_seg.hy};
    assign w_hgt     = {1'b0, i_frame_height};
    assign w_pen_dec = (r_digit == 4'd1) ? EdgeW'({r_size, 2'b00}) : EdgeW'({r_size, 3'b000});

    for (genvar g = 0; g < 4; g++) begin : g_lane
        assign w_term[g] = 18'(w_coef[g]) * 18'($signed({1'b0, r_size}));
        assign w_edge[g] = ((g % 2) == 0 ? r_pen : r_cy)
                         + {{(EdgeW-18){w_term[g][17]}}, w_term[g]};
        assign w_sum[g]  = {r_prod[g][ProdW-1], r_prod[g]}
                         + {{(SumW-ScW){1'b0}}, r_off[g % 2]};
        // floor(m / 100), exact for m below 2^26 / 36
        assign w_rprod[g] = RecProdW'(r_m[g]) * RecProdW'(Recip100);
        assign w_res[g]   = r_neg[g] ? '0 :
                            r_sat[g] ? r_lim[g % 2] : w_rprod[g][37:26];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num       <= w_sat_num;
            r_pen       <= {{(EdgeW-PosW-1){i_pos_x[PosW-1]}}, i_pos_x, 1'b0};
            r_cy        <= {{(EdgeW-PosW-1){i_pos_y[PosW-1]}}, i_pos_y, 1'b0};
            r_size      <= i_glyph_size;
            r_paint     <= i_paint;
            r_off[0]    <= ScW'(ScW'(i_frame_width[CoordW-1:1]) * ScW'(ScaleDen));
            r_off[1]    <= ScW'(ScW'(i_frame_height[CoordW-1:1]) * ScW'(ScaleDen));
            r_lim_sc[0] <= ScW'(ScW'(i_frame_width) * ScW'(ScaleDen));
            r_lim_sc[1] <= ScW'(ScW'(i_frame_height) * ScW'(ScaleDen));
            r_lim[0]    <= i_frame_width;
            r_lim[1]    <= i_frame_height;
        end
        if (i_cmd.digit) begin
            r_digit <= w_rem[DigitW-1:0];
            r_num   <= ValueW'(w_q);
            r_last  <= (w_q == '0);
        end
        if (i_cmd.pen_step) begin
            r_pen <= r_pen - $signed(w_pen_dec);
        end
        for (int i = 0; i < 4; i++) begin
            if (i_cmd.calc) begin
                r_edge[i] <= w_edge[i];
            end
            if (i_cmd.mul) begin
                r_prod[i] <= ProdW'(r_edge[i]) * ProdW'(w_hgt);
            end
            if (i_cmd.add) begin
                r_neg[i] <= w_sum[i][SumW-1];
                r_sat[i] <= !w_sum[i][SumW-1]
                         && (w_sum[i][SumW-2:0] >= {{(SumW-1-ScW){1'b0}}, r_lim_sc[i % 2]});
                r_m[i]   <= w_sum[i][ScW-1:9];
            end
        end
        if (i_cmd.emit) begin
            o_left      <= w_res[0];
            o_top       <= w_res[1];
            o_right     <= w_res[2];
            o_bottom    <= w_res[3];
            o_fill      <= r_paint;
            o_final_res <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.seg_cnt  = seg_count(r_digit);
    assign o_status.last_dig = r_last;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule
`default_nettype wire

// ===== sv/decimal_glyph_rect_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_glyph_rect_generator_core
// Turns a number into block-segment rectangles in frame pixel coordinates.
// ----------------------------------------------------------------------------
// A number item goes in on i_in; the block splits it into decimal digits,
// least significant first (at least one digit, saturated to DIGITS digits),
// and sends one rectangle item per segment on o_out, the last one with
// final_res set. Each rectangle goes through an edge sum, a frame-height
// multiply, a centering add and clamp, and a divide by 100 via reciprocal
// multiply, and each digit starts with a divide by ten. A new number is
// taken once the previous one's last rectangle sits in the output register.
// frame_width (0x0) and frame_height (0x4) are to be written over the APB
// port only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module decimal_glyph_rect_generator_core #(
    parameter int unsigned DIGITS = dgr_pkg::DefDigits
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // item channels
    dgr_in_if.sink           i_in,
    dgr_out_if.source        o_out
);
    import dgr_pkg::*;

    logic [CoordW-1:0] r_frame_width;
    logic [CoordW-1:0] r_frame_height;
    logic              w_wr;
    t_dp_cmd           w_cmd;
    t_dp_status        w_status;

    // APB registers, no wait states
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FrameWidthReset;
            r_frame_height <= FrameHeightReset;
        end else if (w_wr) begin
            if (paddr[2] == RegFrameWidth) begin
                r_frame_width <= pwdata[CoordW-1:0];
            end else begin
                r_frame_height <= pwdata[CoordW-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            RegFrameWidth:  prdata = {{(32-CoordW){1'b0}}, r_frame_width};
            RegFrameHeight: prdata = {{(32-CoordW){1'b0}}, r_frame_height};
            default:        prdata = '0;
        endcase
    end

    // sequencer
    dgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // arithmetic and output register
    dgr_datapath #(
        .DIGITS (DIGITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_value        (i_in.value),
        .i_pos_x        (i_in.pos_x),
        .i_pos_y        (i_in.pos_y),
        .i_glyph_size   (i_in.glyph_size),
        .i_paint        (i_in.paint),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_left         (o_out.left),
        .o_top          (o_out.top),
        .o_right        (o_out.right),
        .o_bottom       (o_out.bottom),
        .o_fill         (o_out.fill),
        .o_final_res    (o_out.final_res)
    );

endmodule
`default_nettype wire

// ===== verif/decimal_glyph_rect_generator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_glyph_rect_generator_core_tb
// Self-checking bench for the number-to-rectangles generator. Number items
// go in with random gaps, and rectangle items are taken with random stalls
// plus one long hold-off. A scoreboard predicts every rectangle from the
// current frame size and checks each field in order. The frame registers
// are rewritten over APB between phases, extremes and zero included.
// ----------------------------------------------------------------------------
module decimal_glyph_rect_generator_core_tb;

    localparam int unsigned NumDigits     = dgr_pkg::DefDigits;
    localparam longint      PxDen         = 51200;  // 512 sub-units * 100
    localparam int unsigned LongHold      = 400;    // sink hold-off, in cycles
    localparam int unsigned WatchdogLimit = 3000;   // cycles with no item moved
    localparam int unsigned DrainCycles   = 150;    // idle wait after the last expected item

    // one number item as driven on the input channel
    typedef struct packed {
        logic [13:0] value;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [11:0] glyph_size;
        logic [31:0] paint;
    } number_t;

    // one rectangle item as seen on the output channel
    typedef struct packed {
        logic [11:0] left;
        logic [11:0] top;
        logic [11:0] right;
        logic [11:0] bottom;
        logic [31:0] fill;
        logic        final_res;
    } rect_t;

    // Segment layout per digit, entry k at index k. Each entry packs
    // {dx, dy, hx, hy} as signed nibbles in half glyph sizes; a zero entry
    // ends the list (every real segment has a nonzero half extent).
    typedef logic [0:6][15:0] glyph_row_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the rectangles of each accepted number and checks
    // the output stream against them in order.
    // ------------------------------------------------------------------------
    class rect_scoreboard;
        rect_t       rects_due[$];
        int unsigned frame_w;
        int unsigned frame_h;
        int unsigned failures;

        function new();
            frame_w  = 640;
            frame_h  = 480;
            failures = 0;
        endfunction

        function void set_reg(logic idx, logic [11:0] v);
            if (idx == dgr_pkg::RegFrameWidth)
                frame_w = v;
            else
                frame_h = v;
        endfunction

        function int unsigned pending();
            return rects_due.size();
        endfunction

        function glyph_row_t glyph_row(int unsigned d);
            glyph_row_t row;
            case (d)
                0: row = {16'hE015, 16'h2015, 16'h0C11, 16'h0411, {3{16'h0}}};
                1: row = {16'h2015, {6{16'h0}}};
                2: row = {16'h0431, 16'h0031, 16'h0C31, 16'h2211, 16'hEE11, {2{16'h0}}};
                3: row = {16'h0431, 16'h0031, 16'h2211, 16'h2E13, 16'h0C31, {2{16'h0}}};
                4: row = {16'h0011, 16'hE213, 16'h2015, {4{16'h0}}};
                5: row = {16'h0431, 16'h0031, 16'h0C31, 16'hE211, 16'h2E11, {2{16'h0}}};
                6: row = {16'h0431, 16'h0031, 16'h0C31, 16'h2211, 16'hEE11, 16'h2E11,
                          16'h0};
                7: row = {16'h0431, 16'h2015, {5{16'h0}}};
                8: row = {16'h0431, 16'h0031, 16'h0C31, 16'h2211, 16'hEE11, 16'h2E11,
                          16'hE211};
                default: row = {16'h0431, 16'h0031, 16'h2211, 16'h2E13, 16'hE211,
                                {2{16'h0}}};
            endcase
            return row;
        endfunction

        // edge at n/512 world units -> centered, truncated, clamped pixel
        function logic [11:0] pixel(longint n, longint half, longint limit);
            longint p;
            p = (n * longint'(frame_h) + half * PxDen) / PxDen;
            if (p < 0)
                p = 0;
            if (p > limit)
                p = limit;
            return p[11:0];
        endfunction

        function void add_number(number_t n);
            longint unsigned num;
            longint unsigned top_value;
            longint          pen_x;
            longint          cy0;
            longint          sz;
            longint          cx;
            longint          cy;
            longint          hx;
            longint          hy;
            int unsigned     d;
            int unsigned     cnt;
            glyph_row_t      row;
            logic [15:0]     e;
            rect_t           r;

            top_value = 1;
            for (int i = 0; i < NumDigits; i++)
                top_value = top_value * 10;
            top_value = top_value - 1;
            num = n.value;
            if (num > top_value)
                num = top_value;

            pen_x = 2 * longint'($signed(n.pos_x));
            cy0   = 2 * longint'($signed(n.pos_y));
            sz    = longint'(n.glyph_size);

            do begin
                d   = int'(num % 10);
                num = num / 10;
                row = glyph_row(d);
                cnt = 0;
                while (cnt < 7 && row[cnt] != 16'h0)
                    cnt++;
                for (int k = 0; k < cnt; k++) begin
                    e  = row[k];
                    cx = pen_x + longint'($signed(e[15:12])) * sz;
                    cy = cy0 + longint'($signed(e[11:8])) * sz;
                    hx = longint'($signed(e[7:4])) * sz;
                    hy = longint'($signed(e[3:0])) * sz;
                    r.left      = pixel(cx - hx, frame_w / 2, frame_w);
                    r.top       = pixel(cy - hy, frame_h / 2, frame_h);
                    r.right     = pixel(cx + hx, frame_w / 2, frame_w);
                    r.bottom    = pixel(cy + hy, frame_h / 2, frame_h);
                    r.fill      = n.paint;
                    r.final_res = (num == 0) && (k == cnt - 1);
                    rects_due.push_back(r);
                end
                pen_x = pen_x - ((d == 1) ? 4 * sz : 8 * sz);
            end while (num != 0);
        endfunction

        function void flag(string what, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            failures++;
        endfunction

        function void check_rect(rect_t got);
            rect_t want;
            if (rects_due.size() == 0) begin
                $display("%0t: unexpected rectangle, expected none actual %0d/%0d/%0d/%0d",
                         $time, got.left, got.top, got.right, got.bottom);
                failures++;
                return;
            end
            want = rects_due.pop_front();
            if (got.left != want.left)
                flag("left", want.left, got.left);
            if (got.top != want.top)
                flag("top", want.top, got.top);
            if (got.right != want.right)
                flag("right", want.right, got.right);
            if (got.bottom != want.bottom)
                flag("bottom", want.bottom, got.bottom);
            if (got.fill != want.fill)
                flag("fill", want.fill, got.fill);
            if (got.final_res != want.final_res)
                flag("final_res", want.final_res, got.final_res);
        endfunction

        function void close();
            if (rects_due.size() != 0) begin
                $display("%0t: expected %0d more rectangles, actual 0",
                         $time, rects_due.size());
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, APB and item channels
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dgr_in_if  num_if ();
    dgr_out_if rect_if ();

    decimal_glyph_rect_generator_core #(
        .DIGITS (NumDigits)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (num_if),
        .o_out   (rect_if)
    );

    rect_scoreboard sb;

    // idling controls, set per phase by the stimulus process
    bit src_idle_on;
    bit sink_idle_on;
    // request for the long sink hold-off; the sink clears it when it starts
    bit hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------

    // Register write: setup cycle, then access cycle; the register takes the
    // value at the access edge. The task then waits with psel low, so
    // back-to-back writes do not lower and raise psel in the same step.
    task automatic apb_write(input logic idx, input logic [11:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // upper bits are junk; only the low 12 should land
        pwdata  <= {20'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [11:0] w, input logic [11:0] h);
        apb_write(dgr_pkg::RegFrameWidth, w);
        apb_write(dgr_pkg::RegFrameHeight, h);
    endtask

    // Offer one number until taken. Valid stays high into the next item
    // unless a random gap is drawn.
    task automatic send_number(input number_t n);
        int unsigned gap;
        num_if.valid      <= 1'b1;
        num_if.value      <= n.value;
        num_if.pos_x      <= n.pos_x;
        num_if.pos_y      <= n.pos_y;
        num_if.glyph_size <= n.glyph_size;
        num_if.paint      <= n.paint;
        do begin
            @(posedge i_clk);
        end while (!(num_if.valid && num_if.ready));
        sb.add_number(n);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            num_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(input logic [13:0] v, input logic [15:0] x,
                               input logic [15:0] y, input logic [11:0] s,
                               input logic [31:0] p);
        number_t n;
        n.value      = v;
        n.pos_x      = x;
        n.pos_y      = y;
        n.glyph_size = s;
        n.paint      = p;
        send_number(n);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Mostly numbers that land on screen with sane glyph sizes; the rest
    // is the full field range. Digit counts are spread evenly, plus some
    // values past the saturation point.
    function automatic number_t rand_number();
        number_t n;
        case ($urandom_range(0, 4))
            0:       n.value = 14'($urandom_range(0, 9));
            1:       n.value = 14'($urandom_range(10, 99));
            2:       n.value = 14'($urandom_range(100, 999));
            3:       n.value = 14'($urandom_range(1000, 9999));
            default: n.value = 14'($urandom_range(0, 16383));
        endcase
        if ($urandom_range(0, 9) < 7) begin
            n.pos_x      = 16'($urandom_range(0, 30000) - 15000);
            n.pos_y      = 16'($urandom_range(0, 24000) - 12000);
            n.glyph_size = 12'($urandom_range(32, 1200));
        end else begin
            n.pos_x      = 16'($urandom);
            n.pos_y      = 16'($urandom);
            n.glyph_size = 12'($urandom);
        end
        n.paint = $urandom;
        return n;
    endfunction

    // One block of random numbers under the current frame size, then drain
    // so the next register write finds the block idle.
    task automatic run_phase(input int count, input bit src_idle, input bit snk_idle,
                             input int hold_at);
        src_idle_on  = src_idle;
        sink_idle_on = snk_idle;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_req = 1'b1;
            send_number(rand_number());
        end
        num_if.valid <= 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Rectangle sink: checks each accepted item, then picks next ready.
    // Long hold-off wins over a short stall burst.
    // ------------------------------------------------------------------------
    initial begin : rect_sink
        int unsigned stall_left;
        int unsigned hold_left;
        rect_t       got;
        stall_left = 0;
        hold_left  = 0;
        rect_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rect_if.valid && rect_if.ready) begin
                got.left      = rect_if.left;
                got.top       = rect_if.top;
                got.right     = rect_if.right;
                got.bottom    = rect_if.bottom;
                got.fill      = rect_if.fill;
                got.final_res = rect_if.final_res;
                sb.check_rect(got);
            end
            if (hold_req) begin
                hold_left = LongHold;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rect_if.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                rect_if.ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                // this cycle counts as the first of the burst
                stall_left = $urandom_range(1, 7) - 1;
                rect_if.ready <= 1'b0;
            end else begin
                rect_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any stretch beyond the limit with no number taken and no
    // expected rectangle taken means a hang. Rectangles beyond the predicted
    // stream do not count, so a block stuck emitting still times out.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WatchdogLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || (num_if.valid && num_if.ready) ||
                (rect_if.valid && rect_if.ready && sb.pending() != 0))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no item moved for %0d cycles", $time, quiet);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        sb = new();

        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        num_if.valid      <= 1'b0;
        num_if.value      <= '0;
        num_if.pos_x      <= '0;
        num_if.pos_y      <= '0;
        num_if.glyph_size <= '0;
        num_if.paint      <= '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset frame size (640x480): every digit,
        // zero, the ones pen step, saturation, zero and max glyph size,
        // position and color extremes.
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_fields(14'd0,     16'h0000, 16'h0000, 12'd256,  32'h0000_0000);
        send_fields(14'd1,     16'h0000, 16'h0000, 12'd256,  32'hFFFF_FFFF);
        send_fields(14'd23,    16'd1000, -16'sd1000, 12'd256, 32'h1234_5678);
        send_fields(14'd456,   -16'sd3000, 16'd2000, 12'd300, 32'h00FF_00FF);
        send_fields(14'd7890,  16'd8000, 16'h0000, 12'd200,  32'hA5A5_5A5A);
        send_fields(14'd1111,  16'd5000, 16'h0000, 12'd512,  32'h0F0F_0F0F);
        send_fields(14'd9999,  16'h0000, 16'h0000, 12'd200,  32'hCAFE_F00D);
        // just past the top and all ones: both saturate to 9999
        send_fields(14'd10000, 16'h0000, 16'h0000, 12'd200,  32'h0000_0001);
        send_fields(14'h3FFF,  16'h0000, 16'h0000, 12'd200,  32'h8000_0000);
        // zero glyph size: every rectangle degenerate but still sent
        send_fields(14'd8,     16'h0000, 16'h0000, 12'd0,    32'h1111_1111);
        send_fields(14'd8,     16'h0000, 16'h0000, 12'hFFF,  32'h2222_2222);
        send_fields(14'd5,     16'h7FFF, 16'h7FFF, 12'd300,  32'h3333_3333);
        send_fields(14'd5,     16'h8000, 16'h8000, 12'd300,  32'h4444_4444);
        send_fields(14'd3,     16'h7FFF, 16'h8000, 12'hFFF,  32'h5555_5555);
        send_fields(14'd6,     16'h8000, 16'h7FFF, 12'hFFF,  32'h6666_6666);
        send_fields(14'd88,    16'h0000, 16'h0000, 12'd1,    32'h7777_7777);
        send_fields(14'd42,    16'h5555, 16'h2AAA, 12'hAAA,  32'h9999_9999);
        num_if.valid <= 1'b0;
        wait_drained();

        // Default size written explicitly; the long sink hold-off lands
        // mid-phase while the source keeps offering.
        set_frame(12'd640, 12'd480);
        run_phase(80, 1'b1, 1'b1, 40);

        // largest frame, then the one-pixel frame
        set_frame(12'hFFF, 12'hFFF);
        run_phase(50, 1'b1, 1'b0, -1);
        set_frame(12'd1, 12'd1);
        run_phase(25, 1'b0, 1'b1, -1);

        // Zero registers: scale and clamp collapse, nothing should fault.
        set_frame(12'd0, 12'd0);
        run_phase(12, 1'b1, 1'b1, -1);
        set_frame(12'd1280, 12'd0);
        run_phase(10, 1'b1, 1'b1, -1);
        set_frame(12'd0, 12'd720);
        run_phase(10, 1'b1, 1'b1, -1);

        // random frame sizes, idling drawn per phase
        repeat (4) begin
            set_frame(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
            run_phase(35, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), -1);
        end

        // closing stretch at full rate on both sides
        set_frame(12'd320, 12'd240);
        run_phase(40, 1'b0, 1'b0, -1);

        // catch anything the block sends after the last expected item
        repeat (DrainCycles) @(posedge i_clk);
        sb.close();
        if (sb.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
